@@ src/sapq_pkg.sv @@
// Shared types and constants for the sorted-array priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package sapq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int PRIO_W      = 8;
  localparam int PORT_VAL_W  = 32;
  localparam int TDATA_W     = 40;
  localparam int CAP_W       = 5;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;
  localparam logic             REG_CAPACITY = 1'b0;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } sapq_mode_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } sapq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ_HEAD,
    S_DEQ_SHIFT,
    S_DONE
  } sapq_state_t;

  typedef struct packed {
    logic         valid;
    sapq_status_t status;
  } sapq_res_t;

endpackage

`default_nettype wire

@@ src/sapq_mem.sv @@
// Entry store of the queue: one write port, one read port, registered read data.
// Uses sapq_pkg for the priority width.
`default_nettype none

module sapq_mem #(
  parameter int DEPTH      = sapq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sapq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]                   wr_addr,
  input  wire logic [VALUE_BITS+sapq_pkg::PRIO_W-1:0]     wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]                   rd_addr,
  output logic      [VALUE_BITS+sapq_pkg::PRIO_W-1:0]     rd_data
);
  import sapq_pkg::*;

  localparam int EW = VALUE_BITS + PRIO_W;

  logic [EW-1:0] mem_r [DEPTH];
  logic [EW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ src/sapq_ctrl.sv @@
// Sequencer and priority comparator: walks the entry store one slot a cycle
// to insert or remove an entry. Uses sapq_pkg; drives sapq_mem.
`default_nettype none

module sapq_ctrl #(
  parameter int DEPTH      = sapq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sapq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_mode,
  input  wire logic [VALUE_BITS-1:0]                  in_value,
  input  wire logic [sapq_pkg::PRIO_W-1:0]            in_prio,
  input  wire logic [sapq_pkg::CAP_W-1:0]             capacity,
  output sapq_pkg::sapq_res_t                         res,
  input  wire logic                                   res_ready,
  output logic      [VALUE_BITS-1:0]                  res_value,
  output logic      [sapq_pkg::PRIO_W-1:0]            res_prio,
  output logic                                        mem_wr_en,
  output logic      [$clog2(DEPTH)-1:0]               mem_wr_addr,
  output logic      [VALUE_BITS+sapq_pkg::PRIO_W-1:0] mem_wr_data,
  output logic                                        mem_rd_en,
  output logic      [$clog2(DEPTH)-1:0]               mem_rd_addr,
  input  wire logic [VALUE_BITS+sapq_pkg::PRIO_W-1:0] mem_rd_data
);
  import sapq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > CAP_W) ? CW : CAP_W;

  sapq_state_t           state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] item_value_r, item_value_nxt;
  logic [PRIO_W-1:0]     item_prio_r, item_prio_nxt;
  sapq_status_t          status_r, status_nxt;
  logic [VALUE_BITS-1:0] res_value_r, res_value_nxt;
  logic [PRIO_W-1:0]     res_prio_r, res_prio_nxt;

  logic                  full;
  logic                  empty;
  logic [PRIO_W-1:0]     rd_prio;

  assign full    = (KW'(count_r) >= KW'(capacity)) || (KW'(count_r) >= KW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_prio = mem_rd_data[VALUE_BITS +: PRIO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    item_value_r <= item_value_nxt;
    item_prio_r  <= item_prio_nxt;
    status_r     <= status_nxt;
    res_value_r  <= res_value_nxt;
    res_prio_r   <= res_prio_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    item_value_nxt = item_value_r;
    item_prio_nxt  = item_prio_r;
    status_nxt     = status_r;
    res_value_nxt  = res_value_r;
    res_prio_nxt   = res_prio_r;
    in_ready       = 1'b0;
    res.valid      = 1'b0;
    res.status     = status_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = pos_r;
    mem_wr_data    = {item_prio_r, item_value_r};
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_value_nxt = in_value;
          item_prio_nxt  = in_prio;
          res_value_nxt  = '0;
          res_prio_nxt   = '0;
          if (in_mode == MODE_ENQ) begin
            if (full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              // start at the tail; fetch the last held entry for the first compare
              status_nxt = ST_ENQ;
              pos_nxt    = AW'(count_r);
              state_nxt  = S_ENQ;
              if (!empty) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(count_r - CW'(1));
              end
            end
          end else begin
            if (empty) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              status_nxt  = ST_DEQ;
              mem_rd_en   = 1'b1;
              state_nxt   = S_DEQ_HEAD;
            end
          end
        end
      end

      S_ENQ: begin
        // read data holds the entry just ahead of pos_r
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r;
        if (pos_r == '0 || rd_prio >= item_prio_r) begin
          mem_wr_data = {item_prio_r, item_value_r};
          count_nxt   = count_r + CW'(1);
          state_nxt   = S_DONE;
        end else begin
          // lower priority: move it one slot back and look further forward
          mem_wr_data = mem_rd_data;
          pos_nxt     = pos_r - AW'(1);
          if (pos_r > AW'(1)) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_r - AW'(2);
          end
        end
      end

      S_DEQ_HEAD: begin
        res_value_nxt = mem_rd_data[VALUE_BITS-1:0];
        res_prio_nxt  = rd_prio;
        if (count_r == CW'(1)) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(1);
          pos_nxt     = AW'(1);
          state_nxt   = S_DEQ_SHIFT;
        end
      end

      S_DEQ_SHIFT: begin
        // move slot pos_r one place forward
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r - AW'(1);
        mem_wr_data = mem_rd_data;
        if ((CW'(pos_r) + CW'(1)) < count_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = pos_r + AW'(1);
          pos_nxt     = pos_r + AW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_value = res_value_r;
  assign res_prio  = res_prio_r;

endmodule

`default_nettype wire

@@ src/sorted_array_priority_queue.sv @@
// Channel    Dir  Contents
// in_        in   tuser: mode; tdata: item_value[31:0], item_priority[39:32]
// out_       out  tuser: status; tdata: out_value[31:0], out_priority[39:32]
// cfg_       in   APB register port, capacity at byte address 0
//
// An enqueue walks back from the tail, moving each held entry of lower priority
// back one slot; a dequeue reads the head and moves every other held entry forward.
// The walk goes one slot a cycle over the entry store; a rejection does no walk.
// Reset (synchronous, rst_n low) empties the queue and sets capacity to 16.
// The block takes no request while one is in progress; a result held in the
// output register by out_tready low stalls the next one from completing.
//
// Top level: APB register, output register and port packing.
// Depends on sapq_pkg, sapq_ctrl and sapq_mem.
`default_nettype none

module sorted_array_priority_queue #(
  parameter int DEPTH      = sapq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sapq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] item_value, [39:32] item_priority
  input  wire logic [sapq_pkg::TDATA_W-1:0]      in_tdata,
  // [0] mode
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] out_value, [39:32] out_priority
  output logic      [sapq_pkg::TDATA_W-1:0]      out_tdata,
  // [1:0] status
  output logic      [1:0]                        out_tuser,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [sapq_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [sapq_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [sapq_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);
  import sapq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = VALUE_BITS + PRIO_W;

  logic [CAP_W-1:0]      cap_r;
  logic                  cfg_wr;

  logic [VALUE_BITS-1:0] in_value;
  logic [PORT_VAL_W-1:0] res_value32;
  sapq_res_t             res;
  logic                  res_ready;
  logic [VALUE_BITS-1:0] res_value;
  logic [PRIO_W-1:0]     res_prio;

  logic                  out_valid_r;
  logic [TDATA_W-1:0]    out_tdata_r;
  logic [1:0]            out_tuser_r;

  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [EW-1:0]         mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [EW-1:0]         mem_rd_data;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_CAPACITY) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(cap_r) : '0;

  // value width adaption between the 32-bit ports and the stored word
  generate
    if (VALUE_BITS <= PORT_VAL_W) begin : g_in_narrow
      assign in_value = in_tdata[VALUE_BITS-1:0];
    end else begin : g_in_wide
      assign in_value = {{(VALUE_BITS-PORT_VAL_W){1'b0}}, in_tdata[PORT_VAL_W-1:0]};
    end
    if (VALUE_BITS >= PORT_VAL_W) begin : g_out_wide
      assign res_value32 = res_value[PORT_VAL_W-1:0];
    end else begin : g_out_narrow
      assign res_value32 = {{(PORT_VAL_W-VALUE_BITS){1'b0}}, res_value};
    end
  endgenerate

  sapq_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tuser),
    .in_value    (in_value),
    .in_prio     (in_tdata[PORT_VAL_W +: PRIO_W]),
    .capacity    (cap_r),
    .res         (res),
    .res_ready   (res_ready),
    .res_value   (res_value),
    .res_prio    (res_prio),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  sapq_mem #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register: load when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_tdata_r <= {res_prio, res_value32};
      out_tuser_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

@@ src/sapq_checker.sv @@
// Port-level checks for sorted_array_priority_queue, attached by bind.
// Uses sapq_pkg for widths and status codes.
`default_nettype none

module sapq_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [sapq_pkg::TDATA_W-1:0] out_tdata,
  input wire logic [1:0]                   out_tuser,
  input wire logic                         cfg_pready
);
  import sapq_pkg::*;

  // a request in progress blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // only a dequeue result carries data
  a_zero_unless_deq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DEQ |-> out_tdata == '0)
    else $error("non-dequeue result with data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port not ready");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for sorted_array_priority_queue: stream requests, APB capacity writes.
// Depends on sapq_pkg and the block's RTL; results are checked against a local queue model.

module testbench;
  import sapq_pkg::*;

  localparam int  DEPTH       = DEPTH_DEF;
  localparam int  RAND_PHASES = 12;
  localparam int  PHASE_ITEMS = 80;
  localparam int  CALM_PHASE  = 10;
  localparam int  TAIL_CYCLES = 40;
  localparam int  MAX_REPORTS = 10;
  localparam longint TIMEOUT_NS = 2_000_000;

  localparam logic [CFG_ADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE    = 3'd4;

  typedef struct packed {
    sapq_status_t status;
    logic [31:0]  value;
    logic [7:0]   prio;
  } pq_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    sapq_mode_t              mode;
    logic [31:0]             value;
    logic [7:0]              prio;
    logic [CFG_ADDR_W-1:0]   addr;
    bit                      has_exp;
    pq_result_t              exp_res;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [TDATA_W-1:0]      in_tdata;   // [31:0] item_value, [39:32] item_priority
  logic                    in_tuser;   // [0] mode
  logic                    out_tvalid;
  logic                    out_tready;
  logic [TDATA_W-1:0]      out_tdata;  // [31:0] out_value, [39:32] out_priority
  logic [1:0]              out_tuser;  // [1:0] status
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_ADDR_W-1:0]   cfg_paddr;
  logic [CFG_DATA_W-1:0]   cfg_pwdata;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  sorted_array_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Local copy of the queue contents and the capacity register
  logic [31:0]        held_val [DEPTH];
  logic [7:0]         held_pri [DEPTH];
  int unsigned        held_n = 0;
  logic [CAP_W-1:0]   cap_reg = CAP_RESET;

  pq_result_t  awaited_results[$];
  dir_row_t    directed_rows[$];
  bit          cur_has_exp = 1'b0;
  pq_result_t  cur_exp;
  bit          calm = 1'b0;
  bit          rx_quiet = 1'b0;
  int          errors = 0;
  int          n_items = 0, n_served = 0, n_full = 0, n_empty = 0, n_cfg = 0;

  function automatic int unsigned eff_capacity();
    return (cap_reg > DEPTH) ? DEPTH : cap_reg;
  endfunction

  // Apply one request to the local queue and return what the block should answer
  function automatic pq_result_t queue_step(sapq_mode_t mode, logic [31:0] value,
                                            logic [7:0] prio);
    pq_result_t  res;
    int unsigned pos;
    res = '{status: ST_ENQ, value: '0, prio: '0};
    if (mode == MODE_ENQ) begin
      if (held_n >= eff_capacity()) begin
        res.status = ST_FULL;
      end else begin
        pos = held_n;
        // move lower priorities back; equal ones stay ahead
        while (pos > 0 && held_pri[pos-1] < prio) begin
          held_val[pos] = held_val[pos-1];
          held_pri[pos] = held_pri[pos-1];
          pos--;
        end
        held_val[pos] = value;
        held_pri[pos] = prio;
        held_n++;
      end
    end else if (held_n == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res = '{status: ST_DEQ, value: held_val[0], prio: held_pri[0]};
      for (int i = 1; i < held_n; i++) begin
        held_val[i-1] = held_val[i];
        held_pri[i-1] = held_pri[i];
      end
      held_n--;
    end
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic void add_item(sapq_mode_t mode, logic [31:0] value, logic [7:0] prio,
                                   bit has_exp = 1'b0, sapq_status_t st = ST_ENQ,
                                   logic [31:0] ev = '0, logic [7:0] ep = '0);
    dir_row_t r;
    r.kind = ROW_ITEM;  r.mode = mode;  r.value = value;  r.prio = prio;  r.addr = '0;
    r.has_exp = has_exp;
    r.exp_res = '{status: st, value: ev, prio: ep};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    dir_row_t r;
    r.kind = ROW_CFG;  r.mode = MODE_ENQ;  r.value = data;  r.prio = '0;  r.addr = addr;
    r.has_exp = 1'b0;
    r.exp_res = '0;
    directed_rows.push_back(r);
  endfunction

  // Score results and predict each accepted request
  always @(posedge clk) begin : scoreboard
    pq_result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{status: sapq_status_t'(out_tuser), value: out_tdata[31:0],
                prio: out_tdata[39:32]};
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result status %0d value %h prio %0d",
                                  got.status, got.value, got.prio));
        end else begin
          want = awaited_results.pop_front();
          if (got !== want)
            note_mismatch($sformatf("status %0d/%0d value %h/%h prio %0d/%0d (exp/got)",
                                    want.status, got.status, want.value, got.value,
                                    want.prio, got.prio));
        end
      end
      if (in_tvalid && in_tready) begin
        want = queue_step(sapq_mode_t'(in_tuser), in_tdata[31:0], in_tdata[39:32]);
        if (cur_has_exp) want = cur_exp;
        n_items++;
        case (want.status)
          ST_DEQ:   n_served++;
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          default: ;
        endcase
        awaited_results.push_back(want);
      end
    end
  end

  // Receiver back-pressure in bursts
  always @(negedge clk) begin : rx_stall
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(sapq_mode_t mode, logic [31:0] value, logic [7:0] prio,
                           bit has_exp, pq_result_t exp_res);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_has_exp = has_exp;
    cur_exp     = exp_res;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {prio, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and hold until every outstanding request has answered
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // Write a register, then read capacity back
  task automatic cfg_write_check(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    logic [CFG_DATA_W-1:0] rd;
    @(negedge clk);
    cfg_psel <= 1'b1;  cfg_penable <= 1'b0;  cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;  cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ADDR_CAPACITY) cap_reg = data[CAP_W-1:0];
    n_cfg++;
    @(negedge clk);
    cfg_penable <= 1'b0;  cfg_pwrite <= 1'b0;  cfg_paddr <= ADDR_CAPACITY;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    if (rd !== {{(CFG_DATA_W-CAP_W){1'b0}}, cap_reg})
      note_mismatch($sformatf("capacity readback %h, expected %0d", rd, cap_reg));
    @(negedge clk);
    cfg_psel <= 1'b0;  cfg_penable <= 1'b0;
  endtask

  initial begin : timeout
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    sapq_mode_t   mode;
    logic [7:0]   prio;
    logic [31:0]  data;
    bit           filling;
    bit           hit;
    int           caps[RAND_PHASES];
    rst_n = 1'b0;
    in_tvalid = 1'b0;  in_tdata = '0;  in_tuser = MODE_ENQ;
    out_tready = 1'b1;
    cfg_psel = 1'b0;  cfg_penable = 1'b0;  cfg_pwrite = 1'b0;
    cfg_paddr = '0;  cfg_pwdata = '0;
    caps = '{31, 0, 16, 1, 2, 17, -1, 8, -1, 3, 16, -1};
    filling = 1'b1;

    // empty queue after reset, extremes, ties in arrival order
    add_item(MODE_DEQ, 32'h0000_0000, 8'd0, 1, ST_EMPTY);
    add_item(MODE_ENQ, 32'h7FFF_FFFF, 8'd255, 1, ST_ENQ);
    add_item(MODE_ENQ, 32'h8000_0000, 8'd0, 1, ST_ENQ);
    add_item(MODE_ENQ, 32'h0000_0000, 8'd0);
    add_item(MODE_ENQ, 32'hFFFF_FFFF, 8'd128);
    add_item(MODE_ENQ, 32'h0000_0001, 8'd255);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_DEQ, 32'h7FFF_FFFF, 8'd255);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_DEQ, 32'h0000_0001, 8'd255);
    add_item(MODE_DEQ, 32'h0, 8'd0);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_DEQ, 32'h8000_0000, 8'd0);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_DEQ, 32'h0000_0000, 8'd0);
    add_item(MODE_DEQ, 32'hFFFF_FFFF, 8'hFF, 1, ST_EMPTY);
    // zero capacity refuses every enqueue
    add_cfg(ADDR_CAPACITY, 32'd0);
    add_item(MODE_ENQ, 32'h5A5A_5A5A, 8'd7, 1, ST_FULL);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_EMPTY);
    add_cfg(ADDR_CAPACITY, 32'd1);
    add_item(MODE_ENQ, 32'h1234_5678, 8'd9, 1, ST_ENQ);
    add_item(MODE_ENQ, 32'hAAAA_AAAA, 8'd200, 1, ST_FULL);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_DEQ, 32'h1234_5678, 8'd9);
    // capacity lowered below the held count: refuse enqueues, still drain
    add_cfg(ADDR_CAPACITY, 32'd3);
    add_item(MODE_ENQ, 32'd11, 8'd3);
    add_item(MODE_ENQ, 32'd22, 8'd5);
    add_item(MODE_ENQ, 32'd33, 8'd4);
    add_cfg(ADDR_CAPACITY, 32'd1);
    add_item(MODE_ENQ, 32'd44, 8'd255, 1, ST_FULL);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_DEQ, 32'd22, 8'd5);
    add_item(MODE_DEQ, 32'h0, 8'd0);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_DEQ, 32'd11, 8'd3);
    // write to an unmapped address leaves capacity alone
    add_cfg(ADDR_SPARE, 32'd0);
    add_item(MODE_ENQ, 32'd55, 8'd1, 1, ST_ENQ);
    add_item(MODE_ENQ, 32'd66, 8'd2, 1, ST_FULL);
    add_item(MODE_DEQ, 32'h0, 8'd0, 1, ST_DEQ, 32'd55, 8'd1);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_drained();
        cfg_write_check(directed_rows[r].addr, directed_rows[r].value);
      end else begin
        send_item(directed_rows[r].mode, directed_rows[r].value, directed_rows[r].prio,
                  directed_rows[r].has_exp, directed_rows[r].exp_res);
      end
    end

    // fill and drain sweeps across capacity settings; the queue carries over
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      calm     = (ph >= CALM_PHASE);
      rx_quiet = (ph % 4 == 1);
      wait_drained();
      data = $urandom;
      data[CAP_W-1:0] = CAP_W'((caps[ph] < 0) ? $urandom_range(0, 31) : caps[ph]);
      cfg_write_check(ADDR_CAPACITY, data);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        if (filling && held_n >= eff_capacity() && $urandom_range(0, 2) == 0)
          filling = 1'b0;
        else if (!filling && held_n == 0 && $urandom_range(0, 2) == 0)
          filling = 1'b1;
        hit  = ($urandom_range(0, 99) < 85);
        mode = (hit == filling) ? MODE_ENQ : MODE_DEQ;
        if ($urandom_range(0, 9) == 0) mode = sapq_mode_t'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0:       prio = 8'($urandom_range(0, 3));
          1:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: prio = 8'($urandom_range(0, 255));
        endcase
        send_item(mode, $urandom, prio, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (awaited_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    $display("ran %0d requests: %0d served, %0d refused full, %0d refused empty",
             n_items, n_served, n_full, n_empty);
    $display("capacity rewritten %0d times, zero and saturated settings included", n_cfg);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
